@@ design/afcu_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and the CRC-8 byte step for the converter frame unpacker.
// No dependencies; imported by adc_frame_crc_check_unpack and its testbench.
package afcu_pkg;

    // Default channel count of one frame
    localparam int CHANNELS_DEF = 8;

    // Field widths
    localparam int WORD_W   = 32;
    localparam int SAMPLE_W = 24;
    localparam int CH_W     = 3;
    localparam int MASK_W   = 4;
    localparam int FAIL_W   = 32;

    // Output tdata: raw, sample, ok, mask, fail count, padded to whole bytes
    localparam int M_FIELDS_W = WORD_W + SAMPLE_W + 1 + MASK_W + FAIL_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // CRC-8, polynomial x^8+x^2+x+1, MSB first, 7 message bytes per pair
    localparam logic [7:0] CRC_POLY  = 8'h07;
    localparam int         CRC_BYTES = 7;
    localparam int         MSG_W     = CRC_BYTES * 8;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_COLLECT,
        ST_RD_W0,
        ST_RD_W1,
        ST_MSG,
        ST_CRC,
        ST_EMIT_RD,
        ST_EMIT_LD
    } t_state;

    // One message byte through the CRC register, bit by bit, MSB first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                             input logic [7:0] data);
        logic [7:0] crc;
        crc = crc_in;
        for (int k = 7; k >= 0; k--) begin
            if (crc[7] != data[k]) begin
                crc = {crc[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[6:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

@@ design/adc_frame_crc_check_unpack.sv @@
`timescale 1ns / 1ps
// Top level of the CRC-checked converter frame unpacker.
// Depends on afcu_pkg and two afcu_ram instances (frame words, held samples).
//
// Accepts one 32-bit channel word per cycle while collecting (tuser = frame
// start, which forces the word to position 0) into a frame RAM. On the word at
// position CHANNELS-1 the block stops taking words and checks each channel pair
// with CRC-8 (poly 0x07, init 0, MSB first, first byte inverted) against the
// nibbles in bits 27:24, reading both words from the frame RAM and running
// the CRC one byte per cycle. It then reads the frame and held-sample RAMs
// once per channel and emits CHANNELS results, one at a time, holding each
// while the output stalls; a good frame is copied into the held-sample RAM on
// the way out. Words are taken again once the last result is in the output
// register. Held samples read as zero until the first good frame; the frame
// RAM needs no clearing.
module adc_frame_crc_check_unpack #(
    parameter int CHANNELS = afcu_pkg::CHANNELS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Input words
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [afcu_pkg::WORD_W-1:0]      i_s_axis_tdata,  // [31:0] word
    input  logic                             i_s_axis_tuser,  // [0] frame_start
    // Per-channel results
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // [31:0] raw_sample, [55:32] sample, [56] frame_ok, [60:57] crc_fail_mask,
    // [92:61] fail_count, [95:93] zero
    output logic [afcu_pkg::M_TDATA_W-1:0]   o_m_axis_tdata,
    output logic [afcu_pkg::CH_W-1:0]        o_m_axis_tuser,  // [2:0] channel
    output logic                             o_m_axis_tlast   // last
);

    import afcu_pkg::*;

    localparam int POS_W  = $clog2(CHANNELS);
    localparam int PAIRS  = CHANNELS / 2;
    localparam int PAIR_W = (PAIRS > 1) ? $clog2(PAIRS) : 1;

    t_state r_state, n_state;

    logic [POS_W-1:0]    r_pos;
    logic [PAIR_W-1:0]   r_pair;
    logic [2:0]          r_byte;
    logic [POS_W-1:0]    r_ch;
    logic [WORD_W-1:0]   r_w0;
    logic [MSG_W-1:0]    r_msg;
    logic [7:0]          r_recv;
    logic [7:0]          r_crc;
    logic                r_ok;
    logic [MASK_W-1:0]   r_mask;
    logic [FAIL_W-1:0]   r_fail;
    logic [CHANNELS-1:0] r_held_vld;

    logic                r_out_valid;
    logic [M_TDATA_W-1:0] r_out_data;
    logic [CH_W-1:0]     r_out_user;
    logic                r_out_last;

    // Handshake and sequencing terms
    logic              in_xfer;
    logic [POS_W-1:0]  wr_pos;
    logic              last_word;
    logic [7:0]        crc_next;
    logic              pair_match;
    logic              crc_done;
    logic              last_pair;
    logic              out_free;
    logic              last_ch;
    logic              load_out;
    logic [MASK_W-1:0] n_mask;

    // RAM ports
    logic              frm_wr_en;
    logic [POS_W-1:0]  frm_wr_addr;
    logic              frm_rd_en;
    logic [POS_W-1:0]  frm_rd_addr;
    logic [WORD_W-1:0] frm_rd_data;
    logic              hld_wr_en;
    logic              hld_rd_en;
    logic [WORD_W-1:0] hld_rd_data;
    logic [WORD_W-1:0] raw_out;

    assign o_s_axis_tready = (r_state == ST_COLLECT);
    assign in_xfer    = i_s_axis_tvalid && o_s_axis_tready;
    assign wr_pos     = i_s_axis_tuser ? '0 : r_pos;
    assign last_word  = (wr_pos == POS_W'(CHANNELS - 1));
    assign crc_next   = crc8_byte(r_crc, r_msg[MSG_W-1 -: 8]);
    assign pair_match = (crc_next == r_recv);
    assign crc_done   = (r_byte == 3'(CRC_BYTES - 1));
    assign last_pair  = (r_pair == PAIR_W'(PAIRS - 1));
    assign out_free   = !r_out_valid || i_m_axis_tready;
    assign last_ch    = (r_ch == POS_W'(CHANNELS - 1));

    // Mismatch flag for the current pair; only the first four pairs have bits
    always_comb begin
        n_mask = r_mask;
        for (int k = 0; k < MASK_W; k++) begin
            if (!pair_match && (int'(r_pair) == k)) begin
                n_mask[k] = 1'b1;
            end
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_COLLECT: begin
                if (in_xfer && last_word) begin
                    n_state = ST_RD_W0;
                end
            end
            ST_RD_W0:   n_state = ST_RD_W1;
            ST_RD_W1:   n_state = ST_MSG;
            ST_MSG:     n_state = ST_CRC;
            ST_CRC: begin
                if (crc_done) begin
                    n_state = last_pair ? ST_EMIT_RD : ST_RD_W0;
                end
            end
            ST_EMIT_RD: n_state = ST_EMIT_LD;
            ST_EMIT_LD: begin
                if (out_free) begin
                    n_state = last_ch ? ST_COLLECT : ST_EMIT_RD;
                end
            end
            default:    n_state = ST_COLLECT;
        endcase
    end

    // RAM controls per state
    always_comb begin
        frm_wr_en   = in_xfer;
        frm_wr_addr = wr_pos;
        frm_rd_en   = 1'b0;
        frm_rd_addr = r_ch;
        hld_rd_en   = 1'b0;
        hld_wr_en   = 1'b0;
        load_out    = 1'b0;
        case (r_state)
            ST_RD_W0: begin
                frm_rd_en   = 1'b1;
                frm_rd_addr = POS_W'({r_pair, 1'b0});
            end
            ST_RD_W1: begin
                frm_rd_en   = 1'b1;
                frm_rd_addr = POS_W'({r_pair, 1'b1});
            end
            ST_EMIT_RD: begin
                frm_rd_en = 1'b1;
                hld_rd_en = 1'b1;
            end
            ST_EMIT_LD: begin
                load_out  = out_free;
                hld_wr_en = out_free && r_ok;
            end
            default: begin
                frm_rd_en = 1'b0;
            end
        endcase
    end

    // Frame words, written in arrival order
    afcu_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CHANNELS)
    ) u_frame_ram (
        .i_clk     (i_clk),
        .i_wr_en   (frm_wr_en),
        .i_wr_addr (frm_wr_addr),
        .i_wr_data (i_s_axis_tdata),
        .i_rd_en   (frm_rd_en),
        .i_rd_addr (frm_rd_addr),
        .o_rd_data (frm_rd_data)
    );

    // Held samples of the last good frame, read per channel, rewritten when the frame is good
    afcu_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CHANNELS)
    ) u_held_ram (
        .i_clk     (i_clk),
        .i_wr_en   (hld_wr_en),
        .i_wr_addr (r_ch),
        .i_wr_data (frm_rd_data),
        .i_rd_en   (hld_rd_en),
        .i_rd_addr (r_ch),
        .o_rd_data (hld_rd_data)
    );

    // Good frame passes its own words; otherwise the held word, zero if never written
    assign raw_out = r_ok ? frm_rd_data :
                     (r_held_vld[r_ch] ? hld_rd_data : '0);

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_COLLECT;
            r_pos       <= '0;
            r_fail      <= '0;
            r_held_vld  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_xfer) begin
                r_pos <= last_word ? '0 : wr_pos + 1'b1;
            end
            if (r_state == ST_CRC && crc_done && last_pair && !(r_ok && pair_match)) begin
                r_fail <= r_fail + 1'b1;
            end
            if (hld_wr_en) begin
                r_held_vld[r_ch] <= 1'b1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Pair check and emission datapath
    always_ff @(posedge i_clk) begin
        if (in_xfer && last_word) begin
            r_pair <= '0;
            r_ok   <= 1'b1;
            r_mask <= '0;
        end
        if (r_state == ST_RD_W1) begin
            r_w0 <= frm_rd_data;
        end
        if (r_state == ST_MSG) begin
            r_msg  <= {~{r_w0[31:28], r_w0[23:20]}, r_w0[19:0],
                       frm_rd_data[31:28], frm_rd_data[23:0]};
            r_recv <= {r_w0[27:24], frm_rd_data[27:24]};
            r_crc  <= '0;
            r_byte <= '0;
        end
        if (r_state == ST_CRC) begin
            r_crc  <= crc_next;
            r_msg  <= {r_msg[MSG_W-9:0], 8'h00};
            r_byte <= r_byte + 1'b1;
            if (crc_done) begin
                r_pair <= r_pair + 1'b1;
                r_mask <= n_mask;
                if (!pair_match) begin
                    r_ok <= 1'b0;
                end
                r_ch <= '0;
            end
        end
        if (load_out) begin
            r_out_data <= M_TDATA_W'({r_fail, r_mask, r_ok,
                                      raw_out[SAMPLE_W-1:0], raw_out});
            r_out_user <= CH_W'(r_ch);
            r_out_last <= last_ch;
            r_ch       <= r_ch + 1'b1;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;
    assign o_m_axis_tlast  = r_out_last;

endmodule

@@ design/afcu_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Stands alone: no package import, no submodules.
module afcu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port; read data holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for adc_frame_crc_check_unpack: streams sealed, corrupted and
// misaligned eight-word frames and checks every per-channel result. Needs afcu_pkg.
module tb;
    import afcu_pkg::*;

    localparam int NCH        = CHANNELS_DEF;
    localparam int NUM_WORDS  = 460;
    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_CYC  = 64;
    localparam int SHOW_MAX   = 10;

    // One channel result as the block should emit it
    typedef struct packed {
        logic [CH_W-1:0]            channel;
        logic [WORD_W-1:0]          raw;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       ok;
        logic [MASK_W-1:0]          mask;
        logic [FAIL_W-1:0]          fails;
        logic                       last;
    } t_chan_result;

    // CRC-8 over the 56 pair bits (bits 27:24 of both words left out), head byte inverted
    function automatic logic [7:0] pair_crc(input logic [31:0] w0, input logic [31:0] w1);
        logic [55:0] msg;
        logic [7:0]  crc;
        logic        fb;
        msg = {~{w0[31:28], w0[23:20]}, w0[19:0], w1[31:28], w1[23:0]};
        crc = 8'h00;
        for (int k = 55; k >= 0; k--) begin
            fb  = crc[7] ^ msg[k];
            crc = {crc[6:0], 1'b0} ^ (fb ? 8'h07 : 8'h00);
        end
        return crc;
    endfunction

    // Tracks frame position, held samples and failure total; queues expected results
    class t_frame_scoreboard;
        logic [WORD_W-1:0] frame_words [NCH];
        logic [WORD_W-1:0] held [NCH];
        int unsigned       position;
        logic [FAIL_W-1:0] fail_total;
        t_chan_result      pending_q [$];
        int                errors;

        function new();
            foreach (held[i]) begin
                held[i]        = '0;
                frame_words[i] = '0;
            end
            position   = 0;
            fail_total = '0;
            errors     = 0;
        endfunction

        // Accepted input word
        function void note_word(logic [WORD_W-1:0] w, logic start);
            logic [MASK_W-1:0] mask;
            logic              ok;
            logic [7:0]        recv;
            t_chan_result      r;
            if (start) position = 0;
            if (position >= NCH) position = 0;
            frame_words[position] = w;
            if (position != NCH - 1) begin
                position++;
                return;
            end
            position = 0;
            mask = '0;
            ok   = 1'b1;
            for (int i = 0; i + 1 < NCH; i += 2) begin
                recv = {frame_words[i][27:24], frame_words[i+1][27:24]};
                if (pair_crc(frame_words[i], frame_words[i+1]) != recv) begin
                    ok = 1'b0;
                    if (i / 2 < MASK_W) mask[i/2] = 1'b1;
                end
            end
            if (ok) begin
                foreach (held[i]) held[i] = frame_words[i];
            end else begin
                fail_total = fail_total + 1'b1;
            end
            for (int i = 0; i < NCH; i++) begin
                r.channel = i[CH_W-1:0];
                r.raw     = held[i];
                r.sample  = held[i][SAMPLE_W-1:0];
                r.ok      = ok;
                r.mask    = mask;
                r.fails   = fail_total;
                r.last    = (i == NCH - 1);
                pending_q.push_back(r);
            end
        endfunction

        // Accepted output transfer against the oldest expectation
        function void check_result(logic [M_TDATA_W-1:0] d, logic [CH_W-1:0] ch, logic lst);
            t_chan_result got;
            t_chan_result want;
            got.channel = ch;
            got.raw     = d[31:0];
            got.sample  = d[55:32];
            got.ok      = d[56];
            got.mask    = d[60:57];
            got.fails   = d[92:61];
            got.last    = lst;
            if (pending_q.size() == 0) begin
                errors++;
                if (errors <= SHOW_MAX)
                    $display("%0t: result with nothing expected: ch=%0d raw=%h", $realtime,
                             got.channel, got.raw);
                return;
            end
            want = pending_q.pop_front();
            if (got.channel !== want.channel || got.raw !== want.raw ||
                got.sample !== want.sample || got.ok !== want.ok ||
                got.mask !== want.mask || got.fails !== want.fails ||
                got.last !== want.last) begin
                errors++;
                if (errors <= SHOW_MAX) begin
                    $display({"%0t: mismatch exp ch=%0d raw=%h smp=%h ok=%b",
                              " mask=%h fails=%0d last=%b"},
                             $realtime, want.channel, want.raw, want.sample, want.ok,
                             want.mask, want.fails, want.last);
                    $display({"%0t:          got ch=%0d raw=%h smp=%h ok=%b",
                              " mask=%h fails=%0d last=%b"},
                             $realtime, got.channel, got.raw, got.sample, got.ok,
                             got.mask, got.fails, got.last);
                end
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [WORD_W-1:0]     i_s_axis_tdata = '0;     // [31:0] word
    logic                  i_s_axis_tuser = 1'b0;   // [0] frame_start
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  o_m_axis_tdata;          // [31:0] raw, [55:32] sample, [56] ok,
                                                    // [60:57] mask, [92:61] fails
    logic [CH_W-1:0]       o_m_axis_tuser;          // [2:0] channel
    logic                  o_m_axis_tlast;

    t_frame_scoreboard sb = new();
    logic [WORD_W-1:0] frame_buf [NCH];
    int words_sent = 0;
    int burst_left = 0;

    adc_frame_crc_check_unpack #(.CHANNELS(NCH)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // Clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Monitor: results checked before the same-edge input is noted
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_result(o_m_axis_tdata, o_m_axis_tuser, o_m_axis_tlast);
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready)
            sb.note_word(i_s_axis_tdata, i_s_axis_tuser);
    end

    // Result-side backpressure: mode re-picked at random among always ready, random, periodic and burst stalls
    int rx_cyc = 0;
    int rx_mode = 0;
    int stall_left = 0;
    always @(posedge i_clk) begin
        rx_cyc++;
        if (rx_cyc % 300 == 0) rx_mode = $urandom_range(0, 3);
        case (rx_mode)
            0: i_m_axis_tready <= 1'b1;
            1: i_m_axis_tready <= 1'($urandom_range(0, 1));
            2: i_m_axis_tready <= (rx_cyc % 4) != 3;
            default: begin
                if (stall_left > 0) begin
                    stall_left--;
                    i_m_axis_tready <= 1'b0;
                end else begin
                    i_m_axis_tready <= 1'b1;
                    if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(5, 30);
                end
            end
        endcase
    end

    // Watchdog: ends the run after a long stretch without any transfer
    initial begin : watchdog
        int idle_cyc;
        idle_cyc = 0;
        while (idle_cyc < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                idle_cyc = 0;
            else
                idle_cyc++;
        end
        $display("tb failed");
        $finish;
    end

    // One input transfer; sender runs in bursts with random gaps between them
    task automatic send_word(input logic [WORD_W-1:0] w, input logic start);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= w;
        i_s_axis_tuser  <= start;
        do @(posedge i_clk); while (!o_s_axis_tready);
        words_sent++;
    endtask

    // Word with a bias toward sample extremes
    function automatic logic [WORD_W-1:0] pick_word();
        logic [WORD_W-1:0] w;
        w = $urandom;
        case ($urandom_range(0, 9))
            0: w[23:0] = 24'h7FFFFF;
            1: w[23:0] = 24'h800000;
            2: w[23:0] = 24'h000000;
            3: w[23:0] = 24'hFFFFFF;
            default: ;
        endcase
        return w;
    endfunction

    // Fills frame_buf with sealed pairs, then spoils the CRC nibble of the pairs in bad
    task automatic build_frame(input logic [MASK_W-1:0] bad, input bit extremes);
        logic [7:0] crc;
        logic [3:0] flip;
        for (int i = 0; i < NCH; i++) frame_buf[i] = pick_word();
        if (extremes) begin
            frame_buf[0] = 32'h007FFFFF;
            frame_buf[1] = 32'hFF800000;
            frame_buf[2] = 32'hFFFFFFFF;
            frame_buf[3] = 32'h00000000;
            frame_buf[4] = 32'hF0FFFFFF;
            frame_buf[5] = 32'h0F000001;
        end
        for (int p = 0; p + 1 < NCH; p += 2) begin
            crc = pair_crc(frame_buf[p], frame_buf[p+1]);
            frame_buf[p][27:24]   = crc[7:4];
            frame_buf[p+1][27:24] = crc[3:0];
            if (p / 2 < MASK_W && bad[p/2]) begin
                flip = 4'($urandom_range(1, 15));
                if ($urandom_range(0, 1)) frame_buf[p][27:24] ^= flip;
                else                      frame_buf[p+1][27:24] ^= flip;
            end
        end
    endtask

    // Sends the first n words of frame_buf
    task automatic send_frame(input int n, input bit with_start);
        for (int i = 0; i < n; i++) send_word(frame_buf[i], with_start && (i == 0));
    endtask

    initial begin : stimulus
        int pick;
        int n;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: all pairs bad before any good frame (held samples still zero)
        build_frame(4'hF, 1'b0);
        send_frame(NCH, 1'b1);
        // Good frame of sample extremes, sent without a start flag
        build_frame(4'h0, 1'b1);
        send_frame(NCH, 1'b0);
        // Start mid-frame, then a frame with the first and last pair bad
        build_frame(4'h0, 1'b0);
        send_frame(2, 1'b1);
        build_frame(4'b1001, 1'b0);
        send_frame(NCH, 1'b1);

        // Random: mostly well-formed frames, some truncated, misaligned or noise
        while (words_sent < NUM_WORDS) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                build_frame(($urandom_range(0, 3) == 0) ? 4'($urandom_range(1, 15)) : 4'h0,
                            $urandom_range(0, 15) == 0);
                send_frame(NCH, 1'b1);
            end else if (pick < 82) begin
                build_frame(4'h0, 1'b0);
                send_frame($urandom_range(1, NCH - 1), 1'b1);
            end else if (pick < 92) begin
                n = $urandom_range(1, 4);
                repeat (n) send_word($urandom, ($urandom_range(0, 3) == 0));
            end else begin
                build_frame(($urandom_range(0, 1) == 0) ? 4'h0 : 4'($urandom_range(1, 15)),
                            1'b0);
                send_frame(NCH, 1'b0);
            end
        end
        i_s_axis_tvalid <= 1'b0;

        // Drain, then let the block settle
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);

        if (sb.pending_q.size() != 0)
            $display("%0d expected results never arrived", sb.pending_q.size());
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
design/afcu_pkg.sv
design/afcu_ram.sv
design/adc_frame_crc_check_unpack.sv
tb/sv/tb.sv
